// File: design/htc_pkg.sv
// Shared types and constants for the tour checker.
// Used by every module of the block except htc_queue; depends on nothing.
package htc_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int QUEUE_DEPTH = 4;
	localparam int VERTEX_W = 9;
	localparam int WEIGHT_W = 16;
	localparam int DIST_W = 32;
	localparam int PATH_W = 16;
	localparam int PDATA_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [VERTEX_W-1:0] VERTEX_COUNT_RESET = 9'd256;

	localparam logic [PADDR_W-3:0] REG_VERTEX_COUNT = 1'b0;

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	typedef enum logic [1:0] {
		VERDICT_MISSING_EDGE = 2'd0,
		VERDICT_NOT_TOUR = 2'd1,
		VERDICT_TOUR = 2'd2,
		VERDICT_SIMPLE_TOUR = 2'd3
	} verdict_t;

	typedef struct packed {
		logic kind;
		logic [VERTEX_W-1:0] vertex_a;
		logic [VERTEX_W-1:0] vertex_b;
		logic [WEIGHT_W-1:0] edge_weight;
		logic path_end;
	} item_t;

	typedef struct packed {
		logic [PATH_W-1:0] path_number;
		logic [DIST_W-1:0] path_distance;
		logic [1:0] verdict;
		logic best_valid;
		logic [PATH_W-1:0] best_path;
		logic [DIST_W-1:0] best_distance;
	} result_t;

	typedef struct packed {
		logic is_path;
		logic first;
		logic last;
		logic vtx_ok;
		logic link_ok;
		logic close_bad;
		logic [VERTEX_W-1:0] vtx;
		logic [WEIGHT_W-1:0] weight;
	} cmd_t;

endpackage

// File: design/htc_queue.sv
// Small FIFO between the classifying front end and the evaluating back end.
// Generic over width and depth; no package dependency.
module htc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] push_data,
	output logic ready,
	input logic pop,
	output logic pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign ready = count_q != CW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/htc_front.sv
// Front end: configuration register, request intake and classification.
// Tracks path start and previous vertex and forms store addresses; uses htc_pkg.
module htc_front #(
	parameter int MAX_VERTICES = htc_pkg::MAX_VERTICES
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [htc_pkg::PADDR_W-1:0] paddr,
	input logic [htc_pkg::PDATA_W-1:0] pwdata,
	output logic [htc_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input logic item_valid,
	output logic item_ready,
	input htc_pkg::item_t item,
	input logic clearing,
	input logic q_ready,
	output logic q_push,
	output htc_pkg::cmd_t q_cmd,
	output logic [2*$clog2(MAX_VERTICES)-1:0] q_addr,
	output logic [htc_pkg::VERTEX_W-1:0] n_active
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CMP_W = 12;

	logic [htc_pkg::VERTEX_W-1:0] vertex_count_q;
	logic in_path_q;
	logic [htc_pkg::VERTEX_W-1:0] start_q;
	logic [htc_pkg::VERTEX_W-1:0] prev_q;
	logic prev_ok_q;
	logic reg_hit;
	logic accept;
	logic is_path;
	logic va_ok;
	logic edge_ok;
	logic [htc_pkg::VERTEX_W-1:0] va;
	logic [htc_pkg::VERTEX_W-1:0] ea;
	logic [htc_pkg::VERTEX_W-1:0] eb;
	logic [htc_pkg::VERTEX_W-1:0] e_lo;
	logic [htc_pkg::VERTEX_W-1:0] e_hi;

	assign pready = 1'b1;
	assign reg_hit = paddr[htc_pkg::PADDR_W-1:2] == htc_pkg::REG_VERTEX_COUNT;
	assign prdata = reg_hit
		? {{(htc_pkg::PDATA_W - htc_pkg::VERTEX_W){1'b0}}, vertex_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= htc_pkg::VERTEX_COUNT_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			vertex_count_q <= pwdata[htc_pkg::VERTEX_W-1:0];
		end
	end

	// clamp to 1..MAX_VERTICES
	always_comb begin
		if (vertex_count_q == '0) begin
			n_active = htc_pkg::VERTEX_W'(1);
		end else if (CMP_W'(vertex_count_q) > CMP_W'(MAX_VERTICES)) begin
			n_active = htc_pkg::VERTEX_W'(MAX_VERTICES);
		end else begin
			n_active = vertex_count_q;
		end
	end

	assign va = item.vertex_a;
	assign is_path = item.kind == htc_pkg::KIND_VERTEX;
	assign va_ok = (va != '0) && (va <= n_active);
	assign edge_ok = (item.vertex_a != '0) && (item.vertex_b != '0)
		&& (CMP_W'(item.vertex_a) <= CMP_W'(MAX_VERTICES))
		&& (CMP_W'(item.vertex_b) <= CMP_W'(MAX_VERTICES));

	assign item_ready = q_ready && !clearing;
	assign accept = item_valid && item_ready;
	// drop edges with an endpoint out of range
	assign q_push = accept && (is_path || edge_ok);

	// symmetric store: keep one entry per pair, lower vertex first
	always_comb begin
		ea = is_path ? prev_q : item.vertex_a;
		eb = is_path ? va : item.vertex_b;
		e_lo = (ea < eb) ? ea : eb;
		e_hi = (ea < eb) ? eb : ea;
		q_addr = {VW'(e_lo - 1'b1), VW'(e_hi - 1'b1)};
	end

	always_comb begin
		q_cmd.is_path = is_path;
		q_cmd.first = !in_path_q;
		q_cmd.last = item.path_end;
		q_cmd.vtx_ok = va_ok;
		q_cmd.link_ok = prev_ok_q && va_ok;
		q_cmd.close_bad = item.path_end && in_path_q && (va != start_q);
		q_cmd.vtx = va;
		q_cmd.weight = item.edge_weight;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_path_q <= 1'b0;
			start_q <= '0;
			prev_q <= '0;
			prev_ok_q <= 1'b0;
		end else if (accept && is_path) begin
			in_path_q <= !item.path_end;
			prev_q <= va;
			prev_ok_q <= va_ok;
			if (!in_path_q) begin
				start_q <= va;
			end
		end
	end

endmodule

// File: design/htc_back.sv
// Back end: adjacency store, path accumulation, verdict and shortest tour.
// Pops requests from htc_queue and drives the result register; uses htc_pkg.
module htc_back #(
	parameter int MAX_VERTICES = htc_pkg::MAX_VERTICES
) (
	input logic clk,
	input logic arst_n,
	input logic [htc_pkg::VERTEX_W-1:0] n_active,
	input logic q_valid,
	input htc_pkg::cmd_t q_cmd,
	input logic [2*$clog2(MAX_VERTICES)-1:0] q_addr,
	output logic q_pop,
	output logic clearing,
	output logic result_valid,
	input logic result_ready,
	output htc_pkg::result_t result
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int AW = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int WORD_W = htc_pkg::WEIGHT_W + 1;
	localparam int DW = htc_pkg::DIST_W;
	localparam int NW = htc_pkg::VERTEX_W;

	logic [WORD_W-1:0] store_q [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic clearing_q;
	logic en;
	logic pop;

	logic v_s1;
	htc_pkg::cmd_t cmd_s1;
	logic [WORD_W-1:0] rdata_s1;

	logic edges_ok_q, no_repeat_q, closes_ok_q;
	logic [DW-1:0] dist_q;
	logic [NW-1:0] count_q;
	logic [NW-1:0] maxv_q;
	logic [MAX_VERTICES-1:0] visited_q;

	logic edges_ok_d, no_repeat_d, closes_ok_d;
	logic [DW-1:0] dist_d;
	logic [NW-1:0] count_d;
	logic [NW-1:0] maxv_d;
	logic [MAX_VERTICES-1:0] visited_d;
	logic [VW-1:0] vidx;
	logic [DW:0] sum;

	logic fv_s2;
	logic edges_ok_s2, no_repeat_s2, closes_ok_s2;
	logic [DW-1:0] dist_s2;
	logic [NW-1:0] count_s2;
	logic [NW-1:0] maxv_s2;

	logic [htc_pkg::PATH_W-1:0] path_ctr_q;
	logic have_best_q;
	logic [htc_pkg::PATH_W-1:0] best_idx_q;
	logic [DW-1:0] best_len_q;
	logic tour;
	logic better;
	logic [htc_pkg::PATH_W-1:0] path_num;
	logic result_valid_q;
	htc_pkg::result_t result_q;

	assign en = !result_valid_q || result_ready;
	assign pop = en && q_valid && !clearing_q;
	assign q_pop = pop;
	assign clearing = clearing_q;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			store_q[clr_addr_q] <= '0;
		end else if (pop && !q_cmd.is_path) begin
			store_q[q_addr] <= {1'b1, q_cmd.weight};
		end
		if (pop && q_cmd.is_path) begin
			rdata_s1 <= store_q[q_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= q_cmd;
		end
	end

	always_comb begin
		edges_ok_d = edges_ok_q;
		no_repeat_d = no_repeat_q;
		closes_ok_d = closes_ok_q;
		dist_d = dist_q;
		count_d = count_q;
		maxv_d = maxv_q;
		visited_d = visited_q;
		vidx = VW'(cmd_s1.vtx - 1'b1);
		sum = {1'b0, dist_q} + (DW + 1)'(rdata_s1[htc_pkg::WEIGHT_W-1:0]);
		if (cmd_s1.first) begin
			visited_d = '0;
			edges_ok_d = cmd_s1.vtx_ok;
			no_repeat_d = 1'b1;
			closes_ok_d = 1'b1;
			dist_d = '0;
			count_d = cmd_s1.vtx_ok ? NW'(1) : '0;
			maxv_d = cmd_s1.vtx_ok ? cmd_s1.vtx : '0;
			if (cmd_s1.vtx_ok) begin
				visited_d[vidx] = 1'b1;
			end
		end else if (edges_ok_q) begin
			if (cmd_s1.close_bad) begin
				closes_ok_d = 1'b0;
			end
			if (!cmd_s1.link_ok || !rdata_s1[WORD_W-1]) begin
				edges_ok_d = 1'b0;
			end else begin
				dist_d = sum[DW] ? '1 : sum[DW-1:0];
				if (!visited_q[vidx]) begin
					visited_d[vidx] = 1'b1;
					count_d = count_q + 1'b1;
					if (cmd_s1.vtx > maxv_q) begin
						maxv_d = cmd_s1.vtx;
					end
				end else if (!cmd_s1.last) begin
					no_repeat_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_ok_q <= 1'b1;
			no_repeat_q <= 1'b1;
			closes_ok_q <= 1'b1;
			dist_q <= '0;
			count_q <= '0;
			maxv_q <= '0;
			visited_q <= '0;
			fv_s2 <= 1'b0;
		end else if (en) begin
			fv_s2 <= v_s1 && cmd_s1.is_path && cmd_s1.last;
			if (v_s1 && cmd_s1.is_path) begin
				edges_ok_q <= edges_ok_d;
				no_repeat_q <= no_repeat_d;
				closes_ok_q <= closes_ok_d;
				dist_q <= dist_d;
				count_q <= count_d;
				maxv_q <= maxv_d;
				visited_q <= visited_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			edges_ok_s2 <= edges_ok_d;
			no_repeat_s2 <= no_repeat_d;
			closes_ok_s2 <= closes_ok_d;
			dist_s2 <= dist_d;
			count_s2 <= count_d;
			maxv_s2 <= maxv_d;
		end
	end

	// all of 1..n visited: n distinct in-range vertices, none above n
	assign tour = edges_ok_s2 && (count_s2 == n_active) && (maxv_s2 <= n_active)
		&& closes_ok_s2;
	assign better = tour && (!have_best_q || (dist_s2 < best_len_q));
	assign path_num = path_ctr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			path_ctr_q <= '0;
			have_best_q <= 1'b0;
			best_idx_q <= '0;
			best_len_q <= '1;
		end else if (en) begin
			result_valid_q <= fv_s2;
			if (fv_s2) begin
				path_ctr_q <= path_num;
				if (better) begin
					have_best_q <= 1'b1;
					best_idx_q <= path_num;
					best_len_q <= dist_s2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && fv_s2) begin
			result_q.path_number <= path_num;
			result_q.path_distance <= edges_ok_s2 ? dist_s2 : '0;
			if (!edges_ok_s2) begin
				result_q.verdict <= htc_pkg::VERDICT_MISSING_EDGE;
			end else if (!tour) begin
				result_q.verdict <= htc_pkg::VERDICT_NOT_TOUR;
			end else if (no_repeat_s2) begin
				result_q.verdict <= htc_pkg::VERDICT_SIMPLE_TOUR;
			end else begin
				result_q.verdict <= htc_pkg::VERDICT_TOUR;
			end
			result_q.best_valid <= have_best_q || better;
			result_q.best_path <= better ? path_num : best_idx_q;
			result_q.best_distance <= better ? dist_s2 : best_len_q;
		end
	end

endmodule

// File: design/hamiltonian_tour_checker_unit.sv
// Top level of the tour checker: front end, request queue and back end.
// Uses htc_pkg, htc_front, htc_queue and htc_back.
//
//   port group       direction  handshake                 payload
//   item             in         item_valid / item_ready   htc_pkg::item_t
//   result           out        result_valid / result_ready htc_pkg::result_t
//   configuration    in/out     psel, penable, pwrite     paddr, pwdata, prdata
//
// One request per cycle is accepted unless the queue is full or the store is clearing.
// The adjacency store read and the distance accumulate each take one stage, followed by
// the result register. After reset item_ready stays low while the store, which holds
// 2^(2*ceil(log2 MAX_VERTICES)) entries (65536 by default), is cleared one entry a cycle.
// A stalled result holds the back end; the queue keeps the front end accepting until full.
module hamiltonian_tour_checker_unit #(
	parameter int MAX_VERTICES = htc_pkg::MAX_VERTICES,
	parameter int QUEUE_DEPTH = htc_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [htc_pkg::PADDR_W-1:0] paddr,
	input logic [htc_pkg::PDATA_W-1:0] pwdata,
	output logic [htc_pkg::PDATA_W-1:0] prdata,
	output logic pready,
	input logic item_valid,
	output logic item_ready,
	input htc_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output htc_pkg::result_t result
);

	localparam int AW = 2 * $clog2(MAX_VERTICES);
	localparam int CMD_W = $bits(htc_pkg::cmd_t);
	localparam int Q_W = AW + CMD_W;

	logic clearing;
	logic q_ready;
	logic q_push;
	htc_pkg::cmd_t f_cmd;
	logic [AW-1:0] f_addr;
	logic [htc_pkg::VERTEX_W-1:0] n_active;
	logic q_pop;
	logic q_valid;
	logic [Q_W-1:0] q_data;
	htc_pkg::cmd_t b_cmd;
	logic [AW-1:0] b_addr;

	htc_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.clearing(clearing),
		.q_ready(q_ready),
		.q_push(q_push),
		.q_cmd(f_cmd),
		.q_addr(f_addr),
		.n_active(n_active)
	);

	htc_queue #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_data({f_addr, f_cmd}),
		.ready(q_ready),
		.pop(q_pop),
		.pop_valid(q_valid),
		.pop_data(q_data)
	);

	assign b_cmd = htc_pkg::cmd_t'(q_data[CMD_W-1:0]);
	assign b_addr = q_data[Q_W-1:CMD_W];

	htc_back #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.n_active(n_active),
		.q_valid(q_valid),
		.q_cmd(b_cmd),
		.q_addr(b_addr),
		.q_pop(q_pop),
		.clearing(clearing),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule

// File: tb/tb.sv
// Self-checking testbench for hamiltonian_tour_checker_unit: edge and path requests in,
// path verdicts out, with a scoreboard that predicts each verdict and the shortest tour.
// Depends on htc_pkg and the block's top level only.
module tb;

	localparam int ITEM_TARGET = 1850;
	localparam int QUIET_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int SPAN_CAP = 8;

	class tour_scoreboard;
		bit [htc_pkg::WEIGHT_W-1:0] weights [htc_pkg::MAX_VERTICES*htc_pkg::MAX_VERTICES];
		bit linked [htc_pkg::MAX_VERTICES*htc_pkg::MAX_VERTICES];
		bit seen [htc_pkg::MAX_VERTICES];
		int unsigned vertex_limit;
		bit in_walk;
		int unsigned origin;
		int unsigned prior;
		int unsigned distinct;
		bit [htc_pkg::DIST_W-1:0] walk_len;
		bit links_ok;
		bit simple;
		bit closed;
		bit [htc_pkg::PATH_W-1:0] paths_done;
		bit have_best;
		bit [htc_pkg::PATH_W-1:0] best_no;
		bit [htc_pkg::DIST_W-1:0] best_len;
		htc_pkg::result_t due[$];
		int errors;
		int useful;

		function new();
			vertex_limit = 32'(htc_pkg::VERTEX_COUNT_RESET);
			links_ok = 1'b1;
			simple = 1'b1;
			closed = 1'b1;
			best_len = '1;
		endfunction

		function void set_vertex_count(int unsigned n);
			vertex_limit = n & 32'h1FF;
		endfunction

		function int unsigned in_use();
			if (vertex_limit < 1) return 1;
			if (vertex_limit > htc_pkg::MAX_VERTICES) return htc_pkg::MAX_VERTICES;
			return vertex_limit;
		endfunction

		function bit vertex_valid(int unsigned v);
			return v >= 1 && v <= in_use();
		endfunction

		function int unsigned slot(int unsigned a, int unsigned b);
			return (a - 1) * htc_pkg::MAX_VERTICES + (b - 1);
		endfunction

		function int pending();
			return due.size();
		endfunction

		task report(string what, longint unsigned got, longint unsigned want);
			$display("tb: %s mismatch, got %0h want %0h", what, got, want);
			errors++;
		endtask

		function void note_request(htc_pkg::item_t req);
			int unsigned a;
			int unsigned b;
			int unsigned n;
			bit all;
			bit [htc_pkg::DIST_W-1:0] add;
			htc_pkg::result_t want;
			a = 32'(req.vertex_a);
			b = 32'(req.vertex_b);
			if (req.kind == htc_pkg::KIND_EDGE) begin
				if (a >= 1 && a <= htc_pkg::MAX_VERTICES && b >= 1
						&& b <= htc_pkg::MAX_VERTICES) begin
					weights[slot(a, b)] = req.edge_weight;
					weights[slot(b, a)] = req.edge_weight;
					linked[slot(a, b)] = 1'b1;
					linked[slot(b, a)] = 1'b1;
					useful++;
				end
				return;
			end
			useful++;
			if (!in_walk) begin
				foreach (seen[i]) seen[i] = 1'b0;
				in_walk = 1'b1;
				origin = a;
				prior = a;
				walk_len = '0;
				simple = 1'b1;
				closed = 1'b1;
				if (vertex_valid(a)) begin
					links_ok = 1'b1;
					seen[a-1] = 1'b1;
					distinct = 1;
				end else begin
					links_ok = 1'b0;
					distinct = 0;
				end
			end else if (links_ok) begin
				if (req.path_end && a != origin) closed = 1'b0;
				if (!vertex_valid(a) || !vertex_valid(prior) || !linked[slot(prior, a)]) begin
					links_ok = 1'b0;
				end else begin
					add = htc_pkg::DIST_W'(weights[slot(prior, a)]);
					if (walk_len > {htc_pkg::DIST_W{1'b1}} - add) walk_len = '1;
					else walk_len = walk_len + add;
					if (!seen[a-1]) begin
						seen[a-1] = 1'b1;
						distinct++;
					end else if (!req.path_end) begin
						simple = 1'b0;
					end
				end
				prior = a;
			end
			if (!req.path_end) return;

			in_walk = 1'b0;
			paths_done++;
			n = in_use();
			want.path_number = paths_done;
			if (!links_ok) begin
				want.verdict = htc_pkg::VERDICT_MISSING_EDGE;
				want.path_distance = '0;
			end else begin
				want.path_distance = walk_len;
				all = 1'b1;
				for (int i = 0; i < n; i++) if (!seen[i]) all = 1'b0;
				if (all && distinct == n && closed) begin
					want.verdict = simple ? htc_pkg::VERDICT_SIMPLE_TOUR : htc_pkg::VERDICT_TOUR;
					if (!have_best || walk_len < best_len) begin
						have_best = 1'b1;
						best_no = paths_done;
						best_len = walk_len;
					end
				end else begin
					want.verdict = htc_pkg::VERDICT_NOT_TOUR;
				end
			end
			want.best_valid = have_best;
			want.best_path = best_no;
			want.best_distance = best_len;
			due.push_back(want);
		endfunction

		task check_result(htc_pkg::result_t got);
			htc_pkg::result_t want;
			if (due.size() == 0) begin
				report("unexpected result", got.path_number, 0);
				return;
			end
			want = due.pop_front();
			if (got.path_number !== want.path_number)
				report("path_number", got.path_number, want.path_number);
			if (got.path_distance !== want.path_distance)
				report("path_distance", got.path_distance, want.path_distance);
			if (got.verdict !== want.verdict)
				report("verdict", got.verdict, want.verdict);
			if (got.best_valid !== want.best_valid)
				report("best_valid", got.best_valid, want.best_valid);
			if (got.best_path !== want.best_path)
				report("best_path", got.best_path, want.best_path);
			if (got.best_distance !== want.best_distance)
				report("best_distance", got.best_distance, want.best_distance);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [htc_pkg::PADDR_W-1:0] paddr;
	logic [htc_pkg::PDATA_W-1:0] pwdata;
	logic [htc_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic item_valid;
	logic item_ready;
	htc_pkg::item_t item;
	logic result_valid;
	logic result_ready;
	htc_pkg::result_t result;

	tour_scoreboard sb;
	bit sender_brisk;
	bit receiver_brisk;
	int result_hold;
	int quiet = 0;
	int unsigned route[$];

	hamiltonian_tour_checker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic htc_pkg::item_t edge_req(int unsigned a, int unsigned b, int unsigned w);
		htc_pkg::item_t req;
		req.kind = htc_pkg::KIND_EDGE;
		req.vertex_a = htc_pkg::VERTEX_W'(a);
		req.vertex_b = htc_pkg::VERTEX_W'(b);
		req.edge_weight = htc_pkg::WEIGHT_W'(w);
		req.path_end = 1'($urandom_range(0, 1));
		return req;
	endfunction

	function automatic htc_pkg::item_t vertex_req(int unsigned v, bit last);
		htc_pkg::item_t req;
		req.kind = htc_pkg::KIND_VERTEX;
		req.vertex_a = htc_pkg::VERTEX_W'(v);
		req.vertex_b = htc_pkg::VERTEX_W'($urandom);
		req.edge_weight = htc_pkg::WEIGHT_W'($urandom);
		req.path_end = last;
		return req;
	endfunction

	function automatic int unsigned pick_weight();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(0, 3);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic send(input htc_pkg::item_t req);
		int gap;
		gap = sender_brisk ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (!item_ready);
		sb.note_request(req);
		@(negedge clk);
	endtask

	// drop valid and wait until every verdict is back and the pipeline is empty
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [htc_pkg::PDATA_W-1:0] wdata,
			output logic [htc_pkg::PDATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {htc_pkg::REG_VERTEX_COUNT, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_vertex_count(input int unsigned n);
		logic [htc_pkg::PDATA_W-1:0] back;
		apb_access(1'b1, n, back);
		sb.set_vertex_count(n);
		apb_access(1'b0, '0, back);
		if (back[htc_pkg::VERTEX_W-1:0] !== n[htc_pkg::VERTEX_W-1:0])
			sb.report("vertex_count readback", back, n);
	endtask

	task automatic walk(input int unsigned span);
		for (int i = 0; i < route.size(); i++) begin
			if (span > 0 && $urandom_range(0, 11) == 0)
				send(edge_req($urandom_range(1, span), $urandom_range(1, span), pick_weight()));
			send(vertex_req(route[i], i == route.size() - 1));
		end
	endtask

	task automatic build_tour(input int unsigned span);
		int unsigned j;
		int unsigned t;
		route.delete();
		for (int unsigned v = 1; v <= span; v++) route.push_back(v);
		for (int i = span - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = route[i];
			route[i] = route[j];
			route[j] = t;
		end
		route.push_back(route[0]);
	endtask

	task automatic run_phase(input int unsigned n);
		int unsigned span;
		int unsigned pick;
		int unsigned steps;
		span = (n > SPAN_CAP) ? SPAN_CAP : n;
		for (int unsigned a = 1; a <= span; a++) begin
			for (int unsigned b = a; b <= span; b++) begin
				if ($urandom_range(0, 9) < ((a == b) ? 5 : 9)) send(edge_req(a, b, pick_weight()));
			end
		end
		repeat (2) send(edge_req($urandom_range(0, 511), $urandom_range(0, 511), pick_weight()));
		repeat ($urandom_range(8, 14)) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				build_tour(span);
				if (pick == 3)
					route.insert($urandom_range(1, route.size() - 1),
						route[$urandom_range(0, route.size() - 2)]);
				if (pick == 4 && route.size() > 2) route.delete($urandom_range(1, route.size() - 2));
				if (pick == 5) route[route.size() - 1] = $urandom_range(0, span + 1);
			end else begin
				route.delete();
				steps = (pick == 9) ? 1 : $urandom_range(1, 2 * span + 2);
				repeat (steps)
					route.push_back(pick == 8 ? $urandom_range(0, 511) : $urandom_range(0, span + 1));
			end
			walk(span);
		end
	endtask

	// hold results off while single-vertex paths keep coming, so the block backs up
	task automatic squeeze(input int unsigned n);
		result_hold = 80;
		sender_brisk = 1'b1;
		repeat (24) send(vertex_req($urandom_range(1, n), 1'b1));
	endtask

	initial begin
		int gap;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = receiver_brisk ? 0 : $urandom_range(0, 4);
			if (result_hold > 0) begin
				gap = result_hold;
				result_hold = 0;
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			sb.check_result(result);
			@(negedge clk);
		end
	end

	initial begin
		int unsigned n;
		int unsigned phase;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		sender_brisk = 1'b0;
		receiver_brisk = 1'b0;
		result_hold = 0;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send(edge_req(0, 5, 7));
		send(edge_req(511, 511, 65535));
		send(edge_req(256, 256, 65535));
		send(edge_req(1, 256, 0));
		send(edge_req(255, 256, 65535));
		send(edge_req(3, 0, 1));
		send(vertex_req(256, 1'b1));
		send(vertex_req(0, 1'b1));
		send(vertex_req(1, 1'b0));
		send(vertex_req(256, 1'b0));
		send(vertex_req(256, 1'b0));
		send(vertex_req(255, 1'b0));
		send(vertex_req(511, 1'b1));
		send(vertex_req(256, 1'b0));
		send(vertex_req(256, 1'b1));
		send(vertex_req(1, 1'b0));
		send(vertex_req(2, 1'b1));
		send(vertex_req(255, 1'b0));
		send(edge_req(2, 3, 5));
		send(vertex_req(256, 1'b1));
		send(vertex_req(257, 1'b1));

		for (int unsigned v = 1; v <= htc_pkg::MAX_VERTICES; v++)
			send(edge_req(v, v % htc_pkg::MAX_VERTICES + 1, $urandom_range(0, 65535)));
		route.delete();
		for (int unsigned v = 1; v <= htc_pkg::MAX_VERTICES; v++) route.push_back(v);
		route.push_back(1);
		walk(0);
		route.delete();
		for (int v = htc_pkg::MAX_VERTICES; v >= 1; v--) route.push_back(v);
		route.push_back(htc_pkg::MAX_VERTICES);
		walk(0);
		settle();

		phase = 0;
		while (sb.useful < ITEM_TARGET) begin
			phase++;
			if (phase == 1) n = 1;
			else if (phase == 3) n = htc_pkg::MAX_VERTICES;
			else n = $urandom_range(2, SPAN_CAP);
			set_vertex_count(n);
			sender_brisk = ($urandom_range(0, 3) == 0);
			receiver_brisk = ($urandom_range(0, 3) == 0);
			if (phase == 2) squeeze(n);
			run_phase(n);
			settle();
		end

		if (sb.errors == 0) $display("tb: done, clean");
		else $display("tb: done, errors");
		$finish;
	end
endmodule
